[src/tlbpt_pkg.sv]
package tlbpt_pkg;

    localparam int PAGE_W     = 8;
    localparam int OFFSET_W   = 8;
    localparam int FRAME_W    = 8;
    localparam int ADDR_W     = PAGE_W + OFFSET_W;
    localparam int COUNT_W    = 32;
    localparam int PAGE_COUNT = 1 << PAGE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // result kinds
    typedef enum logic [1:0] {
        OUT_TLB_HIT   = 2'd0,
        OUT_TABLE_HIT = 2'd1,
        OUT_FAULT     = 2'd2
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture input word, start page table read
        logic commit;  // resolve lookup, update state, fill output register
    } dp_cmd_t;

endpackage

[src/tlb_page_translator.sv]
// channel   dir  width  contents (lowest bit up)
// s_axis    in   16     virt_addr
// m_axis    out  96     frame_index, phys_addr, outcome, tlb_hit_total,
//                       fault_total, zero fill
//
// each word goes through a capture cycle that starts the page table read,
// then a lookup cycle that compares all tlb tags and resolves the result
// the registered page table read sets this split; s_tready is high only in idle
// a finished result waits in the output register while the next word is taken
// if the output register is still full the lookup cycle holds until it drains
// rst_n clears tlb and page table valid bits, pointers and counters at once
module tlb_page_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] virt_addr
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // [7:0] frame_index, [23:8] phys_addr,
                                   // [25:24] outcome, [57:26] tlb_hit_total,
                                   // [89:58] fault_total, [95:90] zero
);

    dp_cmd_t            cmd;
    logic [FRAME_W-1:0] frame_index;
    logic [ADDR_W-1:0]  phys_addr;
    outcome_t           outcome;
    logic [COUNT_W-1:0] tlb_hit_total;
    logic [COUNT_W-1:0] fault_total;

    // sequencing and output handshake
    tlbpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // tlb, page table, allocators and counters
    tlbpt_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .virt_addr     (s_tdata),
        .frame_index   (frame_index),
        .phys_addr     (phys_addr),
        .outcome       (outcome),
        .tlb_hit_total (tlb_hit_total),
        .fault_total   (fault_total)
    );

    assign m_tdata = {6'd0, fault_total, tlb_hit_total, outcome, phys_addr,
                      frame_index};

endmodule

[src/tlbpt_ctrl.sv]
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_LOOKUP:
                cmd.commit = !out_valid_reg || m_tready;
            default:
            begin
                s_tready   = 1'b0;
                cmd.load   = 1'b0;
                cmd.commit = 1'b0;
            end
        endcase
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

[src/tlbpt_dp.sv]
module tlbpt_dp
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [ADDR_W-1:0]   virt_addr,
    output logic [FRAME_W-1:0]  frame_index,
    output logic [ADDR_W-1:0]   phys_addr,
    output outcome_t            outcome,
    output logic [COUNT_W-1:0]  tlb_hit_total,
    output logic [COUNT_W-1:0]  fault_total
);

    localparam int TLB_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [PAGE_W-1:0]   page_reg;
    logic [OFFSET_W-1:0] offset_reg;

    // page table
    logic [FRAME_W-1:0]    table_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]    table_rd_reg;
    logic [PAGE_COUNT-1:0] table_valid_reg;

    // tlb entries
    logic [PAGE_W-1:0]      tlb_tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;

    logic [TLB_W-1:0]   tlb_ptr_reg;
    logic [TLB_W-1:0]   tlb_ptr_next;
    logic [FRAME_W-1:0] frame_ptr_reg;
    logic [FRAME_W-1:0] frame_ptr_next;
    logic [COUNT_W-1:0] hit_cnt_reg;
    logic [COUNT_W-1:0] fault_cnt_reg;

    logic [FRAME_W-1:0]  out_frame_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    outcome_t            out_kind_reg;

    logic               tlb_hit;
    logic [FRAME_W-1:0] tlb_frame_sel;
    logic               table_hit;
    logic               fault;
    logic [FRAME_W-1:0] frame_sel;
    outcome_t           kind_sel;

    // parallel tag compare, lowest matching entry wins
    always_comb
    begin
        tlb_hit       = 1'b0;
        tlb_frame_sel = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && tlb_tag_reg[i] == page_reg)
            begin
                tlb_hit       = 1'b1;
                tlb_frame_sel = tlb_frame_reg[i];
            end
        end
    end

    assign table_hit = table_valid_reg[page_reg];
    assign fault     = !tlb_hit && !table_hit;

    always_comb
    begin
        if (tlb_hit)
        begin
            frame_sel = tlb_frame_sel;
            kind_sel  = OUT_TLB_HIT;
        end
        else if (table_hit)
        begin
            frame_sel = table_rd_reg;
            kind_sel  = OUT_TABLE_HIT;
        end
        else
        begin
            frame_sel = frame_ptr_reg;
            kind_sel  = OUT_FAULT;
        end
    end

    assign tlb_ptr_next   = (tlb_ptr_reg == TLB_W'(TLB_ENTRIES - 1)) ? '0
                                                                     : tlb_ptr_reg + TLB_W'(1);
    assign frame_ptr_next = (frame_ptr_reg == FRAME_W'(FRAME_COUNT - 1)) ? '0
                                                                         : frame_ptr_reg + FRAME_W'(1);

    // page table storage, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit && fault)
            table_mem[page_reg] <= frame_ptr_reg;
        if (cmd.load)
            table_rd_reg <= table_mem[virt_addr[ADDR_W-1:OFFSET_W]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg   <= virt_addr[ADDR_W-1:OFFSET_W];
            offset_reg <= virt_addr[OFFSET_W-1:0];
        end
        if (cmd.commit)
        begin
            out_frame_reg  <= frame_sel;
            out_offset_reg <= offset_reg;
            out_kind_reg   <= kind_sel;
            if (fault)
            begin
                tlb_tag_reg[tlb_ptr_reg]   <= page_reg;
                tlb_frame_reg[tlb_ptr_reg] <= frame_ptr_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_valid_reg <= '0;
            tlb_valid_reg   <= '0;
            tlb_ptr_reg     <= '0;
            frame_ptr_reg   <= '0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            if (tlb_hit && hit_cnt_reg != COUNT_MAX)
                hit_cnt_reg <= hit_cnt_reg + COUNT_W'(1);
            if (fault)
            begin
                if (fault_cnt_reg != COUNT_MAX)
                    fault_cnt_reg <= fault_cnt_reg + COUNT_W'(1);
                table_valid_reg[page_reg] <= 1'b1;
                tlb_valid_reg[tlb_ptr_reg] <= 1'b1;
                tlb_ptr_reg   <= tlb_ptr_next;
                frame_ptr_reg <= frame_ptr_next;
            end
        end
    end

    assign frame_index   = out_frame_reg;
    assign phys_addr     = {out_frame_reg, out_offset_reg};
    assign outcome       = out_kind_reg;
    assign tlb_hit_total = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;

endmodule
